// ===== rtl/core/wtfs_pkg.sv =====
// Shared types and constants for the windowed transfer function sampler.
package wtfs_pkg;

   localparam int MAX_POINTS = 16;
   localparam int PIDX_BITS  = 4;
   localparam int VALUE_BITS = 24;
   localparam int COLOR_BITS = 16;
   localparam int PROD_BITS  = 51;
   localparam int DIVS_BITS  = 25;
   localparam int DCNT_BITS  = 6;

   localparam logic [2:0] CSR_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_CENTER  = 3'd1;
   localparam logic [2:0] CSR_CLAMPED = 3'd2;
   localparam logic [2:0] CSR_DEFMODE = 3'd3;
   localparam logic [2:0] CSR_COUNT   = 3'd4;

   localparam logic       OP_LOAD   = 1'b0;
   localparam logic [1:0] MODE_LIN  = 2'd1;
   localparam logic [1:0] MODE_NEAR = 2'd2;

   typedef logic [3:0][COLOR_BITS-1:0] color_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] pos;
      color_type                    color;
   } point_type;

   typedef struct packed {
      logic                 start;
      logic [PROD_BITS-1:0] dividend;
      logic [DIVS_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] quotient;
      logic [DIVS_BITS-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_MAP, ST_SCAN, ST_PICK,
      ST_BL_M1, ST_BL_M2, ST_BL_ADD, ST_BL_DIV, ST_DONE
   } state_type;

endpackage

// ===== rtl/core/wtfs_cell.sv =====
// One control point cell of the rotating point chain.
module wtfs_cell import wtfs_pkg::*; (
   input  logic      clock,
   input  logic      load_en,
   input  point_type load_point,
   input  logic      shift_en,
   input  point_type shift_point,
   output point_type point
);

   point_type point_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         point_ff <= shift_point;
      end else if (load_en) begin
         point_ff <= load_point;
      end
   end

   assign point = point_ff;

endmodule

// ===== rtl/core/wtfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wtfs_div import wtfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DCNT_BITS-1:0] cnt_ff;
   logic [PROD_BITS-1:0] quo_ff;
   logic [DIVS_BITS-1:0] rem_ff;
   logic [DIVS_BITS-1:0] dvs_ff;
   logic [DIVS_BITS:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[PROD_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DCNT_BITS'(PROD_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_BITS-2:0], fits};
         rem_ff <= fits ? DIVS_BITS'(trial - {1'b0, dvs_ff}) : trial[DIVS_BITS-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/core/windowed_transfer_function_sampler_top.sv =====
// Windowed transfer function sampler: top level with sequencer and datapath.
// A load item writes its point cell and leaves the sequencer idle. A sample
// item is blended only in linear mode with a non-empty segment; nearest mode
// or an empty segment skips the blend. One multiply and a pass through the
// shared divider remap the value, and a zero window width skips both. A full
// rotation of the point chain finds the bracket. Each of the four blended
// channels needs the multiply-add states ST_BL_M1, ST_BL_M2 and ST_BL_ADD and
// another divide. One item is worked at a time. A finished result waits in
// the output register while load items are still taken. The next sample
// holds in its done state for as long as that result is stalled.
module windowed_transfer_function_sampler_top import wtfs_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [PIDX_BITS-1:0]         req_point_index,
   input  logic signed [VALUE_BITS-1:0] req_point_position,
   input  logic [COLOR_BITS-1:0]        req_point_red,
   input  logic [COLOR_BITS-1:0]        req_point_green,
   input  logic [COLOR_BITS-1:0]        req_point_blue,
   input  logic [COLOR_BITS-1:0]        req_point_alpha,
   input  logic signed [VALUE_BITS-1:0] req_sample_value,
   input  logic [1:0]                   req_mode,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [COLOR_BITS-1:0]        rsp_red,
   output logic [COLOR_BITS-1:0]        rsp_green,
   output logic [COLOR_BITS-1:0]        rsp_blue,
   output logic [COLOR_BITS-1:0]        rsp_alpha,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [VALUE_BITS-1:0]        csr_data
);

   state_type state_ff, state_in;

   logic signed [VALUE_BITS-1:0] width_ff, center_ff;
   logic                         clamped_ff, defmode_ff;
   logic [4:0]                   count_ff;

   point_type chain [MAX_POINTS];
   point_type load_point;
   logic      shift_en;
   logic      accept;

   logic signed [VALUE_BITS+2:0] a_ff;
   logic signed [VALUE_BITS:0]   s_ff;
   logic                         neg_ff, wzero_ff;
   logic [DIVS_BITS-1:0]         ud_ff;
   logic signed [VALUE_BITS-1:0] pmin_ff, v_ff;
   logic [1:0]                   mode_ff;
   logic [4:0]                   n_ff;
   color_type                    edge0_ff, edgen_ff;
   logic [PIDX_BITS-1:0]         k_ff;
   logic                         found_ff;
   logic signed [VALUE_BITS-1:0] prev_v_ff, next_v_ff;
   color_type                    prev_c_ff, next_c_ff;
   logic [DIVS_BITS-1:0]         d_ff, t_ff;
   logic [1:0]                   ch_ff;
   logic [PROD_BITS-1:0]         prod_ff, acc_ff;
   color_type                    res_ff;
   logic                         div_wait_ff;
   logic                         rsp_valid_ff;
   color_type                    rsp_ff;

   logic [4:0]                   n_eff;
   logic [PIDX_BITS-1:0]         n_last;
   logic [VALUE_BITS+2:0]        a_neg;
   logic [VALUE_BITS:0]          s_neg;
   logic [VALUE_BITS+1:0]        w2;
   logic [DIVS_BITS:0]           mul_a;
   logic [DIVS_BITS-1:0]         mul_b;
   logic [PROD_BITS-1:0]         mul_p;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;
   logic [PROD_BITS:0]           q_adj;
   logic [DIVS_BITS:0]           q_sat;
   logic signed [VALUE_BITS+3:0] r_full;
   logic signed [VALUE_BITS-1:0] r_sat;
   logic                         linear;
   logic signed [VALUE_BITS:0]   d_s, lo_gap, hi_gap;
   logic                         in_use;
   logic                         rsp_free;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= VALUE_BITS'(128000);
         center_ff  <= VALUE_BITS'(12800);
         clamped_ff <= 1'b0;
         defmode_ff <= 1'b0;
         count_ff   <= 5'd2;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:   width_ff   <= csr_data;
            CSR_CENTER:  center_ff  <= csr_data;
            CSR_CLAMPED: clamped_ff <= csr_data[0];
            CSR_DEFMODE: defmode_ff <= csr_data[0];
            CSR_COUNT:   count_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign load_point.pos   = req_point_position;
   assign load_point.color = {req_point_alpha, req_point_blue, req_point_green, req_point_red};

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      wtfs_cell u_cell (
         .clock       (clock),
         .load_en     (accept && req_op == OP_LOAD && req_point_index == PIDX_BITS'(i)),
         .load_point  (load_point),
         .shift_en    (shift_en),
         .shift_point (chain[(i + 1) % MAX_POINTS]),
         .point       (chain[i])
      );
   end

   assign n_eff  = (count_ff == 5'd0) ? 5'd1 :
                   (count_ff > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : count_ff;
   assign n_last = PIDX_BITS'(n_eff - 5'd1);

   assign a_neg = -a_ff;
   assign s_neg = -s_ff;
   assign w2    = {{2{width_ff[VALUE_BITS-1]}}, width_ff} <<< 1;

   always_comb begin
      case (state_ff)
         ST_BL_M1: begin
            mul_a = {{(DIVS_BITS+1-COLOR_BITS){1'b0}}, prev_c_ff[ch_ff]};
            mul_b = d_ff - t_ff;
         end
         ST_BL_M2: begin
            mul_a = {{(DIVS_BITS+1-COLOR_BITS){1'b0}}, next_c_ff[ch_ff]};
            mul_b = t_ff;
         end
         default: begin
            mul_a = a_ff[VALUE_BITS+2] ? a_neg[DIVS_BITS:0] : a_ff[DIVS_BITS:0];
            mul_b = s_ff[VALUE_BITS] ? s_neg[DIVS_BITS-1:0] : s_ff[DIVS_BITS-1:0];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   wtfs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign q_adj  = {1'b0, div_rsp.quotient} +
                   (PROD_BITS+1)'(neg_ff && div_rsp.remainder != '0);
   assign q_sat  = (q_adj > (PROD_BITS+1)'(1) << (VALUE_BITS+1)) ?
                   (DIVS_BITS+1)'(1) << (VALUE_BITS+1) : q_adj[DIVS_BITS:0];
   assign r_full = (VALUE_BITS+4)'(pmin_ff) +
                   (neg_ff ? -(VALUE_BITS+4)'(q_sat) : (VALUE_BITS+4)'(q_sat));
   assign r_sat  = wzero_ff ? pmin_ff :
                   (r_full > (VALUE_BITS+4)'((1 << (VALUE_BITS-1)) - 1)) ?
                      {1'b0, {(VALUE_BITS-1){1'b1}}} :
                   (r_full < -(VALUE_BITS+4)'(1 << (VALUE_BITS-1))) ?
                      {1'b1, {(VALUE_BITS-1){1'b0}}} : r_full[VALUE_BITS-1:0];

   assign linear = (mode_ff == MODE_LIN) ? 1'b1 :
                   (mode_ff == MODE_NEAR) ? 1'b0 : !defmode_ff;
   assign d_s    = (VALUE_BITS+1)'(next_v_ff) - (VALUE_BITS+1)'(prev_v_ff);
   assign lo_gap = (VALUE_BITS+1)'(v_ff) - (VALUE_BITS+1)'(prev_v_ff);
   assign hi_gap = (VALUE_BITS+1)'(next_v_ff) - (VALUE_BITS+1)'(v_ff);
   assign in_use = {1'b0, k_ff} < n_ff && !found_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && req_op != OP_LOAD) begin
                       state_in = (width_ff == '0) ? ST_MAP : ST_MUL;
                    end
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (div_rsp.done && div_wait_ff) state_in = ST_MAP;
         ST_MAP:    state_in = ST_SCAN;
         ST_SCAN:   if (k_ff == PIDX_BITS'(MAX_POINTS - 1)) state_in = ST_PICK;
         ST_PICK:   state_in = (linear && d_s > 0) ? ST_BL_M1 : ST_DONE;
         ST_BL_M1:  state_in = ST_BL_M2;
         ST_BL_M2:  state_in = ST_BL_ADD;
         ST_BL_ADD: state_in = ST_BL_DIV;
         ST_BL_DIV: if (div_rsp.done && div_wait_ff) begin
                       state_in = (ch_ff == 2'd3) ? ST_DONE : ST_BL_M1;
                    end
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = state_ff != ST_IDLE;
      shift_en         = state_ff == ST_SCAN;
      div_req.start    = (state_ff == ST_DIV || state_ff == ST_BL_DIV) && !div_wait_ff;
      div_req.dividend = (state_ff == ST_DIV) ? prod_ff : acc_ff;
      div_req.divisor  = (state_ff == ST_DIV) ? ud_ff : d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_wait_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_req.start) begin
            div_wait_ff <= 1'b1;
         end else if (div_rsp.done) begin
            div_wait_ff <= 1'b0;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MAP) begin
            found_ff <= 1'b0;
         end else if (state_ff == ST_SCAN && in_use && v_ff < chain[0].pos) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            mode_ff  <= req_mode;
            n_ff     <= n_eff;
            pmin_ff  <= chain[0].pos;
            wzero_ff <= width_ff == '0;
            edge0_ff <= clamped_ff ? '0 : chain[0].color;
            edgen_ff <= clamped_ff ? '0 : chain[n_last].color;
            a_ff     <= ((VALUE_BITS+3)'(req_sample_value) <<< 1)
                        - ((VALUE_BITS+3)'(center_ff) <<< 1) + (VALUE_BITS+3)'(width_ff);
            s_ff     <= (VALUE_BITS+1)'(chain[n_last].pos) - (VALUE_BITS+1)'(chain[0].pos);
            ud_ff    <= w2[VALUE_BITS+1] ? DIVS_BITS'(-w2) : DIVS_BITS'(w2);
         end
         ST_MUL: begin
            prod_ff <= mul_p;
            neg_ff  <= mul_p != '0 &&
                       ((a_ff[VALUE_BITS+2] ^ s_ff[VALUE_BITS]) ^ width_ff[VALUE_BITS-1]);
         end
         ST_MAP: begin
            v_ff      <= r_sat;
            prev_v_ff <= r_sat;
            next_v_ff <= r_sat;
            prev_c_ff <= edge0_ff;
            next_c_ff <= edgen_ff;
            k_ff      <= '0;
         end
         ST_SCAN: begin
            k_ff <= k_ff + 1'b1;
            if (in_use) begin
               if (v_ff < chain[0].pos) begin
                  next_v_ff <= chain[0].pos;
                  next_c_ff <= chain[0].color;
               end else begin
                  prev_v_ff <= chain[0].pos;
                  prev_c_ff <= chain[0].color;
               end
            end
         end
         ST_PICK: begin
            d_ff  <= DIVS_BITS'(d_s);
            t_ff  <= DIVS_BITS'(lo_gap);
            ch_ff <= '0;
            res_ff <= (linear || lo_gap <= hi_gap) ? prev_c_ff : next_c_ff;
         end
         ST_BL_M1: prod_ff <= mul_p;
         ST_BL_M2: begin
            acc_ff  <= prod_ff + PROD_BITS'(d_ff >> 1);
            prod_ff <= mul_p;
         end
         ST_BL_ADD: acc_ff <= acc_ff + prod_ff;
         ST_BL_DIV: if (div_rsp.done && div_wait_ff) begin
            res_ff[ch_ff] <= div_rsp.quotient[COLOR_BITS-1:0];
            ch_ff         <= ch_ff + 1'b1;
         end
         ST_DONE: if (rsp_free) rsp_ff <= res_ff;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_ff[0];
   assign rsp_green = rsp_ff[1];
   assign rsp_blue  = rsp_ff[2];
   assign rsp_alpha = rsp_ff[3];

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && $past(state_ff) != ST_SCAN |-> k_ff == '0)
      else $error("scan did not start at the chain head");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && k_ff == PIDX_BITS'(MAX_POINTS - 1) |=> state_ff != ST_SCAN)
      else $error("chain rotation did not end after a full turn");

   a_found_src: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> $past(state_ff) == ST_SCAN)
      else $error("bracket found outside the scan");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> div_wait_ff)
      else $error("divide finished with no request pending");

endmodule
